/* rtl/core/isbe_pkg.sv */
package isbe_pkg;

  localparam int StackDepthDefault  = 64;
  localparam int LocalsDepthDefault = 256;
  localparam int PcWidthDefault     = 16;

  // commands
  localparam logic [1:0] CMD_EXEC    = 2'd0;
  localparam logic [1:0] CMD_PRELOAD = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;
  localparam logic [1:0] CMD_NOP     = 2'd3;

  // error codes
  localparam logic [2:0] ERR_OK     = 3'd0;
  localparam logic [2:0] ERR_DIV0   = 3'd1;
  localparam logic [2:0] ERR_UNDER  = 3'd2;
  localparam logic [2:0] ERR_OVER   = 3'd3;
  localparam logic [2:0] ERR_UNSUP  = 3'd4;
  localparam logic [2:0] ERR_LOCAL  = 3'd5;
  localparam logic [2:0] ERR_HALTED = 3'd6;

  // configuration register indexes
  localparam logic [1:0] REG_CODE_LENGTH  = 2'd0;
  localparam logic [1:0] REG_STACK_LIMIT  = 2'd1;
  localparam logic [1:0] REG_LOCALS_LIMIT = 2'd2;

  // opcodes
  localparam logic [7:0] OP_ICONST_M1 = 8'h02;
  localparam logic [7:0] OP_ICONST_0  = 8'h03;
  localparam logic [7:0] OP_ICONST_5  = 8'h08;
  localparam logic [7:0] OP_BIPUSH    = 8'h10;
  localparam logic [7:0] OP_SIPUSH    = 8'h11;
  localparam logic [7:0] OP_LDC       = 8'h12;
  localparam logic [7:0] OP_ILOAD     = 8'h15;
  localparam logic [7:0] OP_ILOAD_0   = 8'h1a;
  localparam logic [7:0] OP_ILOAD_3   = 8'h1d;
  localparam logic [7:0] OP_ISTORE    = 8'h36;
  localparam logic [7:0] OP_ISTORE_0  = 8'h3b;
  localparam logic [7:0] OP_ISTORE_3  = 8'h3e;
  localparam logic [7:0] OP_IADD      = 8'h60;
  localparam logic [7:0] OP_ISUB      = 8'h64;
  localparam logic [7:0] OP_IMUL      = 8'h68;
  localparam logic [7:0] OP_IDIV      = 8'h6c;
  localparam logic [7:0] OP_IREM      = 8'h70;
  localparam logic [7:0] OP_INEG      = 8'h74;
  localparam logic [7:0] OP_IINC      = 8'h84;
  localparam logic [7:0] OP_IFEQ      = 8'h99;
  localparam logic [7:0] OP_IFLE      = 8'h9e;
  localparam logic [7:0] OP_IF_ICMPEQ = 8'h9f;
  localparam logic [7:0] OP_IF_ICMPLE = 8'ha4;
  localparam logic [7:0] OP_GOTO      = 8'ha7;
  localparam logic [7:0] OP_IRETURN   = 8'hac;
  localparam logic [7:0] OP_RETURN    = 8'hb1;
  localparam logic [7:0] OP_GETSTATIC = 8'hb2;
  localparam logic [7:0] OP_INVOKEVIRTUAL = 8'hb6;

  // instruction classes decided by the front end
  typedef enum logic [3:0] {
    K_PUSH_CONST, K_PUSH_LOCAL, K_STORE_LOCAL, K_IINC, K_BINOP, K_DIVREM, K_INEG,
    K_IF1, K_IF2, K_GOTO, K_IRETURN, K_RETURN, K_SKIP, K_PRINT, K_UNSUP
  } kind_t;

  // one decoded queue entry
  typedef struct packed {
    logic [1:0]  command;
    kind_t       kind;
    logic [7:0]  opcode;
    logic [7:0]  local_idx;
    logic [31:0] value;     // immediate / constant / preload value
    logic [15:0] offset;    // branch offset from operand_one and operand_two
    logic [1:0]  pc_step;
    logic [1:0]  pops;
    logic        pushes;
  } dec_t;

  // divider request
  typedef struct packed {
    logic        start;
    logic        is_rem;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] result;
  } div_rsp_t;

endpackage

/* rtl/core/isbe_decode.sv */
// Front end: accepts transactions, classifies the opcode, fills a two-entry queue.
module isbe_decode (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          command,
  input  logic [7:0]          opcode,
  input  logic [7:0]          operand_one,
  input  logic [7:0]          operand_two,
  input  logic signed [31:0]  data_word,
  output logic                q_valid,
  input  logic                q_pop,
  output isbe_pkg::dec_t      q_head
);

  isbe_pkg::dec_t dec;
  isbe_pkg::dec_t slot [2];
  logic rd_ptr, wr_ptr;
  logic [1:0] count;
  logic push_en;

  // classification
  always_comb begin
    dec = '0;
    dec.command   = command;
    dec.opcode    = opcode;
    dec.local_idx = operand_one;
    dec.value     = data_word;
    dec.offset    = {operand_one, operand_two};
    dec.kind      = isbe_pkg::K_UNSUP;
    if (opcode >= isbe_pkg::OP_ICONST_M1 && opcode <= isbe_pkg::OP_ICONST_5) begin
      dec.kind = isbe_pkg::K_PUSH_CONST; dec.pushes = 1'b1; dec.pc_step = 2'd1;
      dec.value = 32'(opcode) - 32'(isbe_pkg::OP_ICONST_0);
    end else if (opcode == isbe_pkg::OP_BIPUSH) begin
      dec.kind = isbe_pkg::K_PUSH_CONST; dec.pushes = 1'b1; dec.pc_step = 2'd2;
      dec.value = {{24{operand_one[7]}}, operand_one};
    end else if (opcode == isbe_pkg::OP_SIPUSH) begin
      dec.kind = isbe_pkg::K_PUSH_CONST; dec.pushes = 1'b1; dec.pc_step = 2'd3;
      dec.value = {{16{operand_one[7]}}, operand_one, operand_two};
    end else if (opcode == isbe_pkg::OP_LDC) begin
      dec.kind = isbe_pkg::K_PUSH_CONST; dec.pushes = 1'b1; dec.pc_step = 2'd2;
    end else if (opcode == isbe_pkg::OP_ILOAD ||
                 (opcode >= isbe_pkg::OP_ILOAD_0 && opcode <= isbe_pkg::OP_ILOAD_3)) begin
      dec.kind = isbe_pkg::K_PUSH_LOCAL; dec.pushes = 1'b1;
      dec.pc_step = (opcode == isbe_pkg::OP_ILOAD) ? 2'd2 : 2'd1;
      if (opcode != isbe_pkg::OP_ILOAD) dec.local_idx = opcode - isbe_pkg::OP_ILOAD_0;
    end else if (opcode == isbe_pkg::OP_ISTORE ||
                 (opcode >= isbe_pkg::OP_ISTORE_0 && opcode <= isbe_pkg::OP_ISTORE_3)) begin
      dec.kind = isbe_pkg::K_STORE_LOCAL; dec.pops = 2'd1;
      dec.pc_step = (opcode == isbe_pkg::OP_ISTORE) ? 2'd2 : 2'd1;
      if (opcode != isbe_pkg::OP_ISTORE) dec.local_idx = opcode - isbe_pkg::OP_ISTORE_0;
    end else if (opcode == isbe_pkg::OP_IINC) begin
      dec.kind = isbe_pkg::K_IINC; dec.pc_step = 2'd3;
      dec.value = {{24{operand_two[7]}}, operand_two};
    end else if (opcode == isbe_pkg::OP_IADD || opcode == isbe_pkg::OP_ISUB ||
                 opcode == isbe_pkg::OP_IMUL) begin
      dec.kind = isbe_pkg::K_BINOP; dec.pops = 2'd2; dec.pushes = 1'b1; dec.pc_step = 2'd1;
    end else if (opcode == isbe_pkg::OP_IDIV || opcode == isbe_pkg::OP_IREM) begin
      dec.kind = isbe_pkg::K_DIVREM; dec.pops = 2'd2; dec.pushes = 1'b1; dec.pc_step = 2'd1;
    end else if (opcode == isbe_pkg::OP_INEG) begin
      dec.kind = isbe_pkg::K_INEG; dec.pops = 2'd1; dec.pushes = 1'b1; dec.pc_step = 2'd1;
    end else if (opcode >= isbe_pkg::OP_IFEQ && opcode <= isbe_pkg::OP_IFLE) begin
      dec.kind = isbe_pkg::K_IF1; dec.pops = 2'd1; dec.pc_step = 2'd3;
    end else if (opcode >= isbe_pkg::OP_IF_ICMPEQ && opcode <= isbe_pkg::OP_IF_ICMPLE) begin
      dec.kind = isbe_pkg::K_IF2; dec.pops = 2'd2; dec.pc_step = 2'd3;
    end else if (opcode == isbe_pkg::OP_GOTO) begin
      dec.kind = isbe_pkg::K_GOTO;
    end else if (opcode == isbe_pkg::OP_IRETURN) begin
      dec.kind = isbe_pkg::K_IRETURN; dec.pops = 2'd1;
    end else if (opcode == isbe_pkg::OP_RETURN) begin
      dec.kind = isbe_pkg::K_RETURN;
    end else if (opcode == isbe_pkg::OP_GETSTATIC) begin
      dec.kind = isbe_pkg::K_SKIP; dec.pc_step = 2'd3;
    end else if (opcode == isbe_pkg::OP_INVOKEVIRTUAL) begin
      dec.kind = isbe_pkg::K_PRINT; dec.pops = 2'd1; dec.pc_step = 2'd3;
    end
  end

  assign in_ready = (count != 2'd2);
  assign push_en  = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_head   = slot[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push_en) slot[wr_ptr] <= dec;
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push_en) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push_en) - 2'(q_pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count out of range");
  assert property (@(posedge clk) disable iff (rst)
    (push_en && !q_pop) |=> count == $past(count) + 2'd1)
    else $error("queue count did not follow push");

endmodule

/* rtl/core/isbe_divider.sv */
// Radix-2 restoring divider on magnitudes, Java sign rules; 32 steps a request.
module isbe_divider (
  input  logic                clk,
  input  logic                rst,
  input  isbe_pkg::div_req_t  req,
  output isbe_pkg::div_rsp_t  rsp
);

  logic [31:0] quo, den, rem_q;
  logic [32:0] rem;
  logic [5:0]  steps;
  logic        neg_q, neg_r, is_rem, busy, done;
  logic [32:0] trial;
  logic [31:0] ua, ub;

  assign ua = req.dividend[31] ? (32'd0 - req.dividend) : req.dividend;
  assign ub = req.divisor[31]  ? (32'd0 - req.divisor)  : req.divisor;
  assign trial = {rem[31:0], quo[31]} - {1'b0, den};
  assign rem_q = rem[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy   <= 1'b1;
        steps  <= 6'd32;
        quo    <= ua;
        den    <= ub;
        rem    <= '0;
        is_rem <= req.is_rem;
        neg_q  <= req.dividend[31] ^ req.divisor[31];
        neg_r  <= req.dividend[31];
      end else if (busy) begin
        // one quotient bit a cycle
        if (!trial[32]) begin
          rem <= {1'b0, trial[31:0]};
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= {1'b0, rem[30:0], quo[31]};
          quo <= {quo[30:0], 1'b0};
        end
        steps <= steps - 6'd1;
        if (steps == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy   = busy;
  assign rsp.done   = done;
  assign rsp.result = is_rem ? (neg_r ? 32'd0 - rem_q : rem_q)
                             : (neg_q ? 32'd0 - quo : quo);

  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");
  assert property (@(posedge clk) disable iff (rst) (busy && steps == 6'd1) |=> done)
    else $error("divider did not finish");
  assert property (@(posedge clk) disable iff (rst) busy |-> steps != 6'd0)
    else $error("divider step count lost");

endmodule

/* rtl/core/isbe_execute.sv */
// Back end: reads stack and locals, carries out one queue entry, emits a result.
module isbe_execute #(
  parameter int StackDepth  = isbe_pkg::StackDepthDefault,
  parameter int LocalsDepth = isbe_pkg::LocalsDepthDefault,
  parameter int PcWidth     = isbe_pkg::PcWidthDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [15:0]        code_size,
  input  logic [6:0]         stack_limit,
  input  logic [8:0]         locals_limit,
  input  logic               q_valid,
  output logic               q_pop,
  input  isbe_pkg::dec_t     q_head,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [95:0]        out_data
);

  localparam int SW = $clog2(StackDepth);
  localparam int LW = $clog2(LocalsDepth);
  localparam int CW = $clog2(StackDepth + 1);

  typedef enum logic [2:0] {S_IDLE, S_READ, S_EXEC, S_DIV, S_OUT} state_t;

  state_t state;
  logic [31:0] stack_mem [StackDepth];
  logic [31:0] local_mem [LocalsDepth];
  logic [31:0] top1, top2, loc_rd;
  logic [PcWidth-1:0] pc;
  logic [CW-1:0] cnt;
  logic halted;
  isbe_pkg::dec_t cur;

  // result fields
  logic [15:0] r_pc;
  logic        r_pv, r_rv, r_done;
  logic [31:0] r_pval, r_rval;
  logic [2:0]  r_err;
  logic [6:0]  r_depth;

  isbe_pkg::div_req_t dreq;
  isbe_pkg::div_rsp_t drsp;

  isbe_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // limits in force
  logic [CW:0]  scap;
  logic [9:0]   lcap;
  assign scap = (32'(stack_limit) < StackDepth) ? (CW+1)'(stack_limit) : (CW+1)'(StackDepth);
  assign lcap = (32'(locals_limit) < LocalsDepth) ? 10'(locals_limit) : 10'(LocalsDepth);

  // stack pointers for reads
  logic [SW-1:0] ptr1, ptr2;
  assign ptr1 = SW'(cnt - CW'(1));
  assign ptr2 = SW'(cnt - CW'(2));

  // registered memory reads
  always_ff @(posedge clk) begin
    top1   <= stack_mem[ptr1];
    top2   <= stack_mem[ptr2];
    loc_rd <= local_mem[LW'(cur.local_idx)];
  end

  // execute-stage combinational result
  logic [2:0]  x_err;
  logic        x_halt, x_pv, x_rv, x_wr_stack, x_wr_local;
  logic [31:0] x_val, x_loc_val;
  logic [CW-1:0] x_cnt;
  logic [PcWidth-1:0] x_pc, x_target;
  logic signed [31:0] sa, sb;
  logic [2:0] ck;
  logic cond;
  logic [SW-1:0] x_wptr;
  logic [CW:0] room;

  always_comb begin
    x_err = isbe_pkg::ERR_OK; x_halt = halted; x_pv = 1'b0; x_rv = 1'b0;
    x_val = '0; x_loc_val = '0; x_cnt = cnt; x_pc = pc;
    x_wr_stack = 1'b0; x_wr_local = 1'b0;
    x_target = pc + PcWidth'(cur.offset) - ((cur.offset[15]) ? PcWidth'(17'h10000) : '0);
    sa = '0; sb = '0; ck = '0; cond = 1'b0;
    room = (CW+1)'(cnt) - (CW+1)'(cur.pops) + (CW+1)'(cur.pushes);
    x_wptr = SW'(cnt - CW'(cur.pops));
    case (cur.command)
      isbe_pkg::CMD_EXEC: begin
        if (halted) x_err = isbe_pkg::ERR_HALTED;
        else if (32'(pc) >= 32'(code_size)) x_halt = 1'b1;
        else if (cur.kind == isbe_pkg::K_UNSUP) x_err = isbe_pkg::ERR_UNSUP;
        else if (cnt < CW'(cur.pops)) x_err = isbe_pkg::ERR_UNDER;
        // iinc, goto, return and getstatic leave the stack alone and skip the bound check
        else if ((cur.pops != 2'd0 || cur.pushes) && room > scap) x_err = isbe_pkg::ERR_OVER;
        else if ((cur.kind == isbe_pkg::K_PUSH_LOCAL || cur.kind == isbe_pkg::K_STORE_LOCAL ||
                  cur.kind == isbe_pkg::K_IINC) && 10'(cur.local_idx) >= lcap)
          x_err = isbe_pkg::ERR_LOCAL;
        else if (cur.kind == isbe_pkg::K_DIVREM && top1 == 32'd0) x_err = isbe_pkg::ERR_DIV0;
        else begin
          x_cnt = CW'(room);
          x_pc  = pc + PcWidth'(cur.pc_step);
          case (cur.kind)
            isbe_pkg::K_PUSH_CONST: begin x_val = cur.value; x_wr_stack = 1'b1; end
            isbe_pkg::K_PUSH_LOCAL: begin x_val = loc_rd; x_wr_stack = 1'b1; end
            isbe_pkg::K_STORE_LOCAL: begin x_loc_val = top1; x_wr_local = 1'b1; end
            isbe_pkg::K_IINC: begin x_loc_val = loc_rd + cur.value; x_wr_local = 1'b1; end
            isbe_pkg::K_BINOP: begin
              x_wr_stack = 1'b1;
              if (cur.opcode == isbe_pkg::OP_IADD) x_val = top2 + top1;
              else if (cur.opcode == isbe_pkg::OP_ISUB) x_val = top2 - top1;
              else x_val = 32'(top2 * top1);
            end
            isbe_pkg::K_DIVREM: x_val = '0;
            isbe_pkg::K_INEG: begin x_val = 32'd0 - top1; x_wr_stack = 1'b1; end
            isbe_pkg::K_IF1, isbe_pkg::K_IF2: begin
              if (cur.kind == isbe_pkg::K_IF1) begin
                sa = top1; sb = '0; ck = 3'(cur.opcode - isbe_pkg::OP_IFEQ);
              end else begin
                sa = top2; sb = top1; ck = 3'(cur.opcode - isbe_pkg::OP_IF_ICMPEQ);
              end
              case (ck)
                3'd0: cond = (sa == sb);
                3'd1: cond = (sa != sb);
                3'd2: cond = (sa < sb);
                3'd3: cond = (sa >= sb);
                3'd4: cond = (sa > sb);
                default: cond = (sa <= sb);
              endcase
              if (cond) x_pc = x_target;
            end
            isbe_pkg::K_GOTO: x_pc = x_target;
            isbe_pkg::K_IRETURN: begin x_rv = 1'b1; x_val = top1; x_halt = 1'b1; end
            isbe_pkg::K_RETURN: x_halt = 1'b1;
            isbe_pkg::K_PRINT: begin x_pv = 1'b1; x_val = top1; end
            default: x_val = '0;
          endcase
        end
        if (x_err != isbe_pkg::ERR_OK && x_err != isbe_pkg::ERR_HALTED) x_halt = 1'b1;
      end
      isbe_pkg::CMD_PRELOAD: begin
        if (10'(cur.local_idx) >= lcap) x_err = isbe_pkg::ERR_LOCAL;
        else begin x_loc_val = cur.value; x_wr_local = 1'b1; end
      end
      isbe_pkg::CMD_RESTART: begin
        x_pc = '0; x_cnt = '0; x_halt = 1'b0;
      end
      default: ;
    endcase
  end

  logic div_go;
  assign div_go = (cur.command == isbe_pkg::CMD_EXEC) && !halted &&
                  (32'(pc) < 32'(code_size)) && (cur.kind == isbe_pkg::K_DIVREM) &&
                  (x_err == isbe_pkg::ERR_OK);
  assign dreq.start    = (state == S_EXEC) && div_go;
  assign dreq.is_rem   = (cur.opcode == isbe_pkg::OP_IREM);
  assign dreq.dividend = top2;
  assign dreq.divisor  = top1;
  assign q_pop = (state == S_IDLE) && q_valid;

  // sequencer with state and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; pc <= '0; cnt <= '0; halted <= 1'b0; out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (q_valid) begin cur <= q_head; state <= S_READ; end
        S_READ: state <= S_EXEC;
        S_EXEC: begin
          pc <= x_pc; cnt <= x_cnt; halted <= x_halt;
          r_pc <= 16'(x_pc); r_done <= x_halt; r_err <= x_err; r_depth <= 7'(x_cnt);
          r_pv <= x_pv; r_pval <= x_pv ? x_val : '0;
          r_rv <= x_rv; r_rval <= x_rv ? x_val : '0;
          if (x_wr_stack) stack_mem[x_wptr] <= x_val;
          if (x_wr_local) local_mem[LW'(cur.local_idx)] <= x_loc_val;
          if (div_go) state <= S_DIV;
          else begin state <= S_OUT; out_valid <= 1'b1; end
        end
        // count already dropped by one, so the quotient or remainder lands on the new top
        S_DIV: if (drsp.done) begin
          stack_mem[ptr1] <= drsp.result;
          state <= S_OUT; out_valid <= 1'b1;
        end
        S_OUT: if (out_ready) begin out_valid <= 1'b0; state <= S_IDLE; end
        default: state <= S_IDLE;
      endcase
    end
  end

  // tdata: next_pc, print_valid, print_value, done_res, return_valid,
  // return_value, error_code, stack_depth
  assign out_data = {3'd0, r_depth, r_err, r_rval, r_rv, r_done, r_pval, r_pv, r_pc};

  assert property (@(posedge clk) disable iff (rst) out_valid |-> state == S_OUT)
    else $error("result shown outside output state");
  assert property (@(posedge clk) disable iff (rst) 32'(cnt) <= StackDepth)
    else $error("stack count beyond depth");
  assert property (@(posedge clk) disable iff (rst) (state == S_DIV) |-> !q_pop)
    else $error("queue popped during divide");

endmodule

/* rtl/core/integer_stack_bytecode_executor_unit.sv */
// A result passes through queue pop, stack read and execute when the back end is idle;
// idiv and irem also wait for the radix-2 divider to finish.
// The back end takes one item at a time (pop, read, execute, output handshake), held by the
// registered stack read and the single execute sequencer; idiv/irem wait on the divider.
// Reset (rst, synchronous): pc, stack count and halted clear; stack and locals
// hold undefined data until written; config returns to 65535, 64, 256.
module integer_stack_bytecode_executor_unit #(
  parameter int StackDepth  = isbe_pkg::StackDepthDefault,
  parameter int LocalsDepth = isbe_pkg::LocalsDepthDefault,
  parameter int PcWidth     = isbe_pkg::PcWidthDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // command[1:0], opcode[9:2], operand_one[17:10], operand_two[25:18], data_word[57:26]
  input  logic [63:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // next_pc[15:0], print_valid[16], print_value[48:17], done_res[49],
  // return_valid[50], return_value[82:51], error_code[85:83], stack_depth[92:86]
  output logic [95:0]  m_axis_tdata,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  logic [15:0] code_size;
  logic [6:0]  stack_limit;
  logic [8:0]  locals_limit;
  logic        q_valid, q_pop;
  isbe_pkg::dec_t q_head;
  logic [95:0] res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      code_size    <= 16'd65535;
      stack_limit  <= 7'd64;
      locals_limit <= 9'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        isbe_pkg::REG_CODE_LENGTH:  code_size    <= cfg_data;
        isbe_pkg::REG_STACK_LIMIT:  stack_limit  <= cfg_data[6:0];
        isbe_pkg::REG_LOCALS_LIMIT: locals_limit <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  isbe_decode u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .command(s_axis_tdata[1:0]), .opcode(s_axis_tdata[9:2]),
    .operand_one(s_axis_tdata[17:10]), .operand_two(s_axis_tdata[25:18]),
    .data_word(s_axis_tdata[57:26]),
    .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head)
  );

  isbe_execute #(.StackDepth(StackDepth), .LocalsDepth(LocalsDepth), .PcWidth(PcWidth))
  u_back (
    .clk(clk), .rst(rst),
    .code_size(code_size), .stack_limit(stack_limit), .locals_limit(locals_limit),
    .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(res)
  );

  assign m_axis_tdata = res;

endmodule
